>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every enabled clock edge
`define VRS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// expr must never be true
`define VRS_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

>>> hdl/vrs_pkg.sv
// ----------------------------------------------------------------------------
// vrs_pkg
// Widths, constants and types of the Snell refraction pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vrs_pkg;

	localparam int unsigned CMP_W  = 16;  // input and output components
	localparam int unsigned ETA_W  = 16;
	localparam int unsigned PRD_W  = 32;  // d_i * n_i
	localparam int unsigned DOT_W  = 33;  // dot and cosine, Q.28
	localparam int unsigned CN_W   = 48;  // c * n_i
	localparam int unsigned SUM_W  = 49;  // d_i * 2^28 + c * n_i
	localparam int unsigned T_W    = 26;  // Q.20
	localparam int unsigned TE_W   = 42;  // t * eta
	localparam int unsigned P_W    = 28;  // perpendicular part, Q.20
	localparam int unsigned SQ_W   = 55;  // p_i^2
	localparam int unsigned LEN_W  = 57;
	localparam int unsigned RAD_W  = 56;  // |1 - |p|^2|, Q.40
	localparam int unsigned ROOT_W = 28;  // Q.20
	localparam int unsigned REM_W  = 30;
	localparam int unsigned SN_W   = 44;  // s * n_i
	localparam int unsigned Q_W    = 30;
	localparam int unsigned O_W    = 24;

	localparam logic signed [DOT_W-1:0] ONE_Q28 = DOT_W'(64'sd1 <<< 28);
	localparam logic [LEN_W-1:0]        ONE_Q40 = LEN_W'(64'd1 << 40);

	localparam logic signed [CMP_W-1:0] SAT_MAX = 16'sh7fff;
	localparam logic signed [CMP_W-1:0] SAT_MIN = 16'sh8000;

	typedef logic signed [CMP_W-1:0] comp_t;
	typedef logic signed [P_W-1:0]   pcomp_t;

	// sideband carried through the square root
	typedef struct packed {
		pcomp_t [2:0] p;
		comp_t  [2:0] n;
	} vrs_side_t;

	typedef struct packed {
		comp_t x;
		comp_t y;
		comp_t z;
		logic  clip;
	} vrs_res_t;

endpackage

`default_nettype wire

>>> hdl/vrs_in_if.sv
// ----------------------------------------------------------------------------
// vrs_in_if
// Request channel: incident direction, surface normal and index ratio.
// ----------------------------------------------------------------------------
`default_nettype none

interface vrs_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [15:0] dir_z;
	logic signed [15:0] norm_x;
	logic signed [15:0] norm_y;
	logic signed [15:0] norm_z;
	logic        [15:0] eta_ratio;

	modport source (
		output valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_ratio,
		input  ready
	);
	modport sink (
		input  valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_ratio,
		output ready
	);
endinterface

`default_nettype wire

>>> hdl/vrs_out_if.sv
// ----------------------------------------------------------------------------
// vrs_out_if
// Result channel: refracted direction in Q4.12 and the clip flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface vrs_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic signed [15:0] out_z;
	logic               clipped;

	modport source (
		output valid, out_x, out_y, out_z, clipped,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, out_z, clipped,
		output ready
	);
endinterface

`default_nettype wire

>>> hdl/vrs_isqrt.sv
// ----------------------------------------------------------------------------
// vrs_isqrt
// Pipelined floor square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module vrs_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [vrs_pkg::RAD_W-1:0]  rad,
	input  vrs_pkg::vrs_side_t         in_side,
	output logic                       out_valid,
	output logic [vrs_pkg::ROOT_W-1:0] root,
	output vrs_pkg::vrs_side_t         out_side
);
	import vrs_pkg::*;

	localparam int unsigned N = ROOT_W;

	// element k holds the state after stage k
	logic              v_sk    [N];
	logic [RAD_W-1:0]  rad_sk  [N];
	logic [REM_W-1:0]  rem_sk  [N];
	logic [ROOT_W-1:0] root_sk [N];
	vrs_side_t         side_sk [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic              src_v;
		logic [RAD_W-1:0]  src_rad;
		logic [REM_W-1:0]  src_rem;
		logic [ROOT_W-1:0] src_root;
		vrs_side_t         src_side;
		logic [REM_W+1:0]  cur;
		logic [REM_W+1:0]  trial;
		logic              ge;

		if (k == 0) begin : g_first
			always_comb begin
				src_v    = in_valid;
				src_rad  = rad;
				src_rem  = '0;
				src_root = '0;
				src_side = in_side;
			end
		end else begin : g_next
			always_comb begin
				src_v    = v_sk[k-1];
				src_rad  = rad_sk[k-1];
				src_rem  = rem_sk[k-1];
				src_root = root_sk[k-1];
				src_side = side_sk[k-1];
			end
		end

		always_comb begin
			cur   = {src_rem, src_rad[RAD_W-1 -: 2]};
			trial = {{(REM_W-ROOT_W){1'b0}}, src_root, 2'b01};
			ge    = (cur >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[k] <= 1'b0;
			end else if (en) begin
				v_sk[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_sk[k]  <= src_rad << 2;
				rem_sk[k]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
				root_sk[k] <= {src_root[ROOT_W-2:0], ge};
				side_sk[k] <= src_side;
			end
		end
	end

	assign out_valid = v_sk[N-1];
	assign root      = root_sk[N-1];
	assign out_side  = side_sk[N-1];

endmodule

`default_nettype wire

>>> hdl/vector_refraction_snell.sv
// ----------------------------------------------------------------------------
// vector_refraction_snell
// Snell refraction of a unit direction about a unit normal, Q2.14 in,
// Q4.12 out with saturation.
//
//   channel  dir  payload                                      format
//   ray      in   dir_x/y/z, norm_x/y/z, eta_ratio             Q2.14, u Q2.14
//   res      out  out_x/y/z, clipped                           Q4.12, flag
//
// One request per cycle while the skid register is empty; 8 arithmetic stages, a
// 28-stage bit-per-stage square root and 2 output stages.
// arst_n clears all valid bits and the valid flag of the output skid register.
// A stalled result is parked in a skid register; while it is full the whole
// pipeline holds and ray.ready is low, so ready depends on no input.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module vector_refraction_snell (
	input logic        clk,
	input logic        arst_n,
	vrs_in_if.sink     ray,
	vrs_out_if.source  res
);
	import vrs_pkg::*;

	logic     adv;
	logic     skid_v_q;
	vrs_res_t skid_q;

	assign adv       = !skid_v_q;
	assign ray.ready = adv;

	// stage 1: d_i * n_i
	comp_t                   din [3];
	comp_t                   nin [3];
	logic signed [PRD_W-1:0] dn_c [3];
	logic                    v_s1;
	comp_t                   d_s1 [3];
	comp_t                   n_s1 [3];
	logic [ETA_W-1:0]        eta_s1;
	logic signed [PRD_W-1:0] dn_s1 [3];

	always_comb begin
		din[0] = ray.dir_x;
		din[1] = ray.dir_y;
		din[2] = ray.dir_z;
		nin[0] = ray.norm_x;
		nin[1] = ray.norm_y;
		nin[2] = ray.norm_z;
		for (int i = 0; i < 3; i++) begin
			dn_c[i] = PRD_W'(din[i]) * PRD_W'(nin[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1   <= din;
			n_s1   <= nin;
			eta_s1 <= ray.eta_ratio;
			dn_s1  <= dn_c;
		end
	end

	// stage 2: cosine, clamped above at one
	logic signed [DOT_W-1:0] dot_c;
	logic signed [DOT_W-1:0] cos_c;
	logic                    v_s2;
	comp_t                   d_s2 [3];
	comp_t                   n_s2 [3];
	logic [ETA_W-1:0]        eta_s2;
	logic signed [DOT_W-1:0] c_s2;

	always_comb begin
		dot_c = DOT_W'(dn_s1[0]) + DOT_W'(dn_s1[1]) + DOT_W'(dn_s1[2]);
		cos_c = -dot_c;
		if (cos_c > ONE_Q28) begin
			cos_c = ONE_Q28;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s2   <= d_s1;
			n_s2   <= n_s1;
			eta_s2 <= eta_s1;
			c_s2   <= cos_c;
		end
	end

	// stage 3: c * n_i
	logic signed [CN_W-1:0] cn_c [3];
	logic                   v_s3;
	comp_t                  d_s3 [3];
	comp_t                  n_s3 [3];
	logic [ETA_W-1:0]       eta_s3;
	logic signed [CN_W-1:0] cn_s3 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cn_c[i] = CN_W'(c_s2) * CN_W'(n_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s3   <= d_s2;
			n_s3   <= n_s2;
			eta_s3 <= eta_s2;
			cn_s3  <= cn_c;
		end
	end

	// stage 4: t_i = rnd(d_i * 2^28 + c * n_i, 22)
	logic signed [SUM_W-1:0] sum_c [3];
	logic signed [T_W-1:0]   t_c [3];
	logic                    v_s4;
	comp_t                   n_s4 [3];
	logic [ETA_W-1:0]        eta_s4;
	logic signed [T_W-1:0]   t_s4 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = (SUM_W'(d_s3[i]) <<< 28) + SUM_W'(cn_s3[i])
			         + (SUM_W'(1) <<< 21);
			t_c[i]   = T_W'(sum_c[i] >>> 22);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s4   <= n_s3;
			eta_s4 <= eta_s3;
			t_s4   <= t_c;
		end
	end

	// stage 5: t_i * eta
	logic signed [TE_W-1:0] te_c [3];
	logic                   v_s5;
	comp_t                  n_s5 [3];
	logic signed [TE_W-1:0] te_s5 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			te_c[i] = TE_W'(t_s4[i]) * TE_W'($signed({1'b0, eta_s4}));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s5  <= n_s4;
			te_s5 <= te_c;
		end
	end

	// stage 6: p_i = rnd(t_i * eta, 14)
	logic signed [TE_W-1:0] ter_c [3];
	logic                   v_s6;
	comp_t                  n_s6 [3];
	pcomp_t                 p_s6 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ter_c[i] = te_s5[i] + (TE_W'(1) <<< 13);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s6 <= n_s5;
			for (int i = 0; i < 3; i++) begin
				p_s6[i] <= P_W'(ter_c[i] >>> 14);
			end
		end
	end

	// stage 7: p_i^2
	logic signed [SQ_W:0] sq_c [3];
	logic                 v_s7;
	comp_t                n_s7 [3];
	pcomp_t               p_s7 [3];
	logic [SQ_W-1:0]      pp_s7 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_c[i] = (SQ_W+1)'(p_s6[i]) * (SQ_W+1)'(p_s6[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s7 <= n_s6;
			p_s7 <= p_s6;
			for (int i = 0; i < 3; i++) begin
				pp_s7[i] <= sq_c[i][SQ_W-1:0];
			end
		end
	end

	// stage 8: |1 - |p|^2|
	logic [LEN_W-1:0] len_c;
	logic [LEN_W-1:0] diff_c;
	logic             v_s8;
	logic [RAD_W-1:0] diff_s8;
	vrs_side_t        side_s8;

	always_comb begin
		len_c  = LEN_W'(pp_s7[0]) + LEN_W'(pp_s7[1]) + LEN_W'(pp_s7[2]);
		diff_c = (len_c >= ONE_Q40) ? (len_c - ONE_Q40) : (ONE_Q40 - len_c);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s8 <= diff_c[RAD_W-1:0];
			for (int i = 0; i < 3; i++) begin
				side_s8.p[i] <= p_s7[i];
				side_s8.n[i] <= n_s7[i];
			end
		end
	end

	// stages 9 to 36: square root
	logic              v_sq;
	logic [ROOT_W-1:0] s_sq;
	vrs_side_t         side_sq;

	vrs_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s8),
		.rad       (diff_s8),
		.in_side   (side_s8),
		.out_valid (v_sq),
		.root      (s_sq),
		.out_side  (side_sq)
	);

	// stage 37: s * n_i
	logic signed [SN_W:0]   sn_c [3];
	logic                   v_s37;
	pcomp_t                 p_s37 [3];
	logic signed [SN_W-1:0] sn_s37 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sn_c[i] = (SN_W+1)'($signed({1'b0, s_sq}))
			        * (SN_W+1)'($signed(side_sq.n[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				p_s37[i]  <= $signed(side_sq.p[i]);
				sn_s37[i] <= SN_W'(sn_c[i]);
			end
		end
	end

	// stage 38: q_i, output rounding and saturation
	logic signed [SN_W-1:0] snr_c [3];
	logic signed [Q_W-1:0]  q_c [3];
	logic signed [31:0]     od_c [3];
	logic signed [O_W-1:0]  o_c [3];
	comp_t                  sat_c [3];
	logic [2:0]             clip_c;
	logic                   v_s38;
	vrs_res_t               res_s38;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			snr_c[i] = sn_s37[i] + (SN_W'(1) <<< 13);
			q_c[i]   = Q_W'(snr_c[i] >>> 14);
			od_c[i]  = 32'(p_s37[i]) - 32'(q_c[i]) + 32'sd128;
			o_c[i]   = O_W'(od_c[i] >>> 8);
			if (o_c[i] > O_W'(SAT_MAX)) begin
				sat_c[i]  = SAT_MAX;
				clip_c[i] = 1'b1;
			end else if (o_c[i] < O_W'(SAT_MIN)) begin
				sat_c[i]  = SAT_MIN;
				clip_c[i] = 1'b1;
			end else begin
				sat_c[i]  = CMP_W'(o_c[i]);
				clip_c[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s38.x    <= sat_c[0];
			res_s38.y    <= sat_c[1];
			res_s38.z    <= sat_c[2];
			res_s38.clip <= |clip_c;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s37 <= 1'b0;
			v_s38 <= 1'b0;
		end else if (adv) begin
			v_s1  <= ray.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s37 <= v_sq;
			v_s38 <= v_s37;
		end
	end

	// output skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (res.ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (v_s38 && !res.ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			skid_q <= res_s38;
		end
	end

	assign res.valid   = skid_v_q || v_s38;
	assign res.out_x   = skid_v_q ? skid_q.x    : res_s38.x;
	assign res.out_y   = skid_v_q ? skid_q.y    : res_s38.y;
	assign res.out_z   = skid_v_q ? skid_q.z    : res_s38.z;
	assign res.clipped = skid_v_q ? skid_q.clip : res_s38.clip;

	// checks
	logic on_rail_c;

	assign on_rail_c = (res.out_x == SAT_MAX) || (res.out_x == SAT_MIN)
	                 || (res.out_y == SAT_MAX) || (res.out_y == SAT_MIN)
	                 || (res.out_z == SAT_MAX) || (res.out_z == SAT_MIN);

	`VRS_ASSERT(a_skid_fill, $rose(skid_v_q) |-> $past(v_s38 && !res.ready))
	`VRS_ASSERT(a_skid_holds_pipe, skid_v_q |=> ($stable(v_s38) && $stable(res_s38)))
	`VRS_NEVER(a_clip_off_rail, res.valid && res.clipped && !on_rail_c)

endmodule

`default_nettype wire
